// File: rtl/core/scpr_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// Second-chance page replacement: shared definitions
// Widths, codes, controller states and the command and status bundles that
// pass between the controller and the datapath.
// ---------------------------------------------------------------------------
package scpr_pkg;

    // Default sizes for the top-level parameters.
    localparam int DEF_FRAMES = 8;
    localparam int DEF_PAGES  = 16;

    // Field widths.
    localparam int PAGE_W     = 4;
    localparam int CFG_W      = 4;
    localparam int SLOT_OUT_W = 3;
    localparam int EVICT_W    = 5;
    localparam int FAULT_W    = 16;
    localparam int S_TDATA_W  = 8;
    localparam int M_TDATA_W  = 32;

    // Configuration port.
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic [APB_ADDR_W-3:0] REG_FRAMES_IN_USE = 1'b0;
    localparam logic [CFG_W-1:0]      CFG_FRAMES_RESET  = 4'd8;

    localparam logic [EVICT_W-1:0] EMPTY_MARK = 5'd16;
    localparam logic [FAULT_W-1:0] FAULT_MAX  = 16'hFFFF;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SRCH_RD,
        ST_SRCH_CMP,
        ST_HIT_WR,
        ST_FAULT,
        ST_SW_SLOT,
        ST_SW_REF,
        ST_SW_DECIDE,
        ST_OUT
    } scpr_state_t;

    typedef struct packed {
        logic clr_step;    // clear one reference bit after reset
        logic load_page;   // capture the incoming page
        logic cnt_clr;     // restart the resident search
        logic cnt_inc;     // next slot of the search
        logic fault_step;  // count the fault and bring the hand into range
        logic sw_rd_slot;  // read the slot under the hand
        logic sw_rd_ref;   // capture that slot's page, read its reference bit
        logic hit_wr;      // set the reference bit of a hit
        logic sw_skip;     // give the slot a second chance and move on
        logic sw_take;     // place the new page under the hand
        logic out_load;    // move the result into the output register
    } scpr_cmd_t;

    typedef struct packed {
        logic clr_done;
        logic match;
        logic cnt_last;
        logic victim;
        logic out_free;
    } scpr_sts_t;

endpackage
`default_nettype wire

// File: rtl/core/scpr_ram.sv
`default_nettype none
// ---------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module scpr_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 8
) (
    input  wire logic                                   aclk,
    input  wire logic                                   we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                       wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// File: rtl/core/scpr_ctrl.sv
`default_nettype none
// ---------------------------------------------------------------------------
// Second-chance page replacement: controller
// Sequences the clearing pass, the resident search, the clock sweep and the
// hand-over of each result word.
// ---------------------------------------------------------------------------
module scpr_ctrl
    import scpr_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_tvalid,
    output logic           s_tready,
    input  wire scpr_sts_t sts,
    output scpr_cmd_t      cmd
);

    scpr_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (sts.clr_done) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_tvalid) state_next = ST_SRCH_RD;
            end
            ST_SRCH_RD:  state_next = ST_SRCH_CMP;
            ST_SRCH_CMP: begin
                priority if (sts.match) begin
                    state_next = ST_HIT_WR;
                end else if (sts.cnt_last) begin
                    state_next = ST_FAULT;
                end else begin
                    state_next = ST_SRCH_RD;
                end
            end
            ST_HIT_WR:  state_next = ST_OUT;
            ST_FAULT:   state_next = ST_SW_SLOT;
            ST_SW_SLOT: state_next = ST_SW_REF;
            ST_SW_REF:  state_next = ST_SW_DECIDE;
            ST_SW_DECIDE: begin
                state_next = sts.victim ? ST_OUT : ST_SW_SLOT;
            end
            ST_OUT: begin
                if (sts.out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            ST_CLEAR: cmd.clr_step = 1'b1;
            ST_IDLE: begin
                s_tready      = 1'b1;
                cmd.load_page = s_tvalid;
                cmd.cnt_clr   = s_tvalid;
            end
            ST_SRCH_RD: ;
            ST_SRCH_CMP: cmd.cnt_inc = !sts.match && !sts.cnt_last;
            ST_HIT_WR:   cmd.hit_wr = 1'b1;
            ST_FAULT:    cmd.fault_step = 1'b1;
            ST_SW_SLOT:  cmd.sw_rd_slot = 1'b1;
            ST_SW_REF:   cmd.sw_rd_ref = 1'b1;
            ST_SW_DECIDE: begin
                cmd.sw_take = sts.victim;
                cmd.sw_skip = !sts.victim;
            end
            ST_OUT: cmd.out_load = sts.out_free;
            default: ;
        endcase
    end

endmodule
`default_nettype wire

// File: rtl/core/scpr_datapath.sv
`default_nettype none
// ---------------------------------------------------------------------------
// Second-chance page replacement: datapath
// Slot and reference-bit memories, clock hand, fault counter, result and
// output registers.
// ---------------------------------------------------------------------------
module scpr_datapath
    import scpr_pkg::*;
#(
    parameter int FRAMES = DEF_FRAMES,
    parameter int PAGES  = DEF_PAGES
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire scpr_cmd_t               cmd,
    output scpr_sts_t                    sts,
    input  wire logic [CFG_W-1:0]        n_used,
    input  wire logic [PAGE_W-1:0]       s_page,
    input  wire logic                    m_tready,
    output logic                         m_tvalid,
    output logic                         m_hit,
    output logic      [SLOT_OUT_W-1:0]   m_frame_slot,
    output logic      [EVICT_W-1:0]      m_evicted_page,
    output logic      [FAULT_W-1:0]      m_fault_count
);

    localparam int SW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int PW = $clog2(PAGES);
    localparam int CW = ((SW > CFG_W) ? SW : CFG_W) + 1;
    localparam int MOD_STEPS = 8;

    // Page number modulo PAGES by repeated subtraction; the value is only
    // four bits wide, so a handful of steps always suffice.
    function automatic logic [PAGE_W-1:0] page_mod(input logic [PAGE_W-1:0] p);
        logic [PAGE_W-1:0] r;
        r = p;
        for (int k = 0; k < MOD_STEPS; k++) begin
            if (r >= PAGES) r = PAGE_W'(r - PAGES);
        end
        return r;
    endfunction

    function automatic logic [PW-1:0] ref_idx(input logic [PAGE_W-1:0] p);
        return PW'(p);
    endfunction

    logic [PAGE_W-1:0]  page_reg, page_next;
    logic [PAGE_W-1:0]  vic_reg, vic_next;
    logic [SW-1:0]      cnt_reg, cnt_next;
    logic [SW-1:0]      hand_reg, hand_next;
    logic [SW-1:0]      hand_adv;
    logic [FAULT_W-1:0] faults_reg, faults_next;
    logic [FRAMES-1:0]  valid_reg, valid_next;
    logic [PW-1:0]      clr_reg, clr_next;
    logic               res_hit_reg, res_hit_next;
    logic [SW-1:0]      res_slot_reg, res_slot_next;
    logic [EVICT_W-1:0] res_evict_reg, res_evict_next;
    logic               m_tvalid_reg, m_tvalid_next;
    logic               m_hit_reg;
    logic [SLOT_OUT_W-1:0] m_slot_reg;
    logic [EVICT_W-1:0] m_evict_reg;
    logic [FAULT_W-1:0] m_fault_reg;

    logic [PAGE_W-1:0]  slot_rdata;
    logic [SW-1:0]      slot_raddr;
    logic               ref_rdata;
    logic               ref_we;
    logic [PW-1:0]      ref_waddr;

    assign slot_raddr = cmd.sw_rd_slot ? hand_reg : cnt_reg;

    scpr_ram #(
        .WIDTH (PAGE_W),
        .DEPTH (FRAMES)
    ) u_slot_ram (
        .aclk  (aclk),
        .we    (cmd.sw_take),
        .waddr (hand_reg),
        .wdata (page_reg),
        .raddr (slot_raddr),
        .rdata (slot_rdata)
    );

    assign ref_we = cmd.clr_step | cmd.hit_wr | cmd.sw_skip;

    always_comb begin
        priority if (cmd.clr_step) begin
            ref_waddr = clr_reg;
        end else if (cmd.hit_wr) begin
            ref_waddr = ref_idx(page_reg);
        end else begin
            ref_waddr = ref_idx(vic_reg);
        end
    end

    // The reference bit of whatever page the slot memory returns is read
    // in the following cycle; only the sweep makes use of it.
    scpr_ram #(
        .WIDTH (1),
        .DEPTH (PAGES)
    ) u_ref_ram (
        .aclk  (aclk),
        .we    (ref_we),
        .waddr (ref_waddr),
        .wdata (cmd.hit_wr),
        .raddr (ref_idx(slot_rdata)),
        .rdata (ref_rdata)
    );

    assign sts.clr_done = (clr_reg == PW'(PAGES - 1));
    assign sts.match    = valid_reg[cnt_reg] && (slot_rdata == page_reg);
    assign sts.cnt_last = (CW'(cnt_reg) + CW'(1)) >= CW'(n_used);
    assign sts.victim   = !valid_reg[hand_reg] || !ref_rdata;
    assign sts.out_free = !m_tvalid_reg || m_tready;

    assign hand_adv = ((CW'(hand_reg) + CW'(1)) >= CW'(n_used)) ? '0 : SW'(hand_reg + 1'b1);

    always_comb begin
        page_next      = cmd.load_page ? page_mod(s_page) : page_reg;
        vic_next       = cmd.sw_rd_ref ? slot_rdata : vic_reg;
        clr_next       = cmd.clr_step ? PW'(clr_reg + 1'b1) : clr_reg;
        cnt_next       = cnt_reg;
        hand_next      = hand_reg;
        faults_next    = faults_reg;
        valid_next     = valid_reg;
        res_hit_next   = res_hit_reg;
        res_slot_next  = res_slot_reg;
        res_evict_next = res_evict_reg;

        if (cmd.cnt_clr) begin
            cnt_next = '0;
        end else if (cmd.cnt_inc) begin
            cnt_next = SW'(cnt_reg + 1'b1);
        end

        if (cmd.fault_step) begin
            if (faults_reg != FAULT_MAX) faults_next = faults_reg + 1'b1;
            // The hand may sit beyond the slots in use after the count shrank.
            if (CW'(hand_reg) >= CW'(n_used)) hand_next = '0;
        end

        if (cmd.sw_skip || cmd.sw_take) begin
            hand_next = hand_adv;
        end

        if (cmd.hit_wr) begin
            res_hit_next   = 1'b1;
            res_slot_next  = cnt_reg;
            res_evict_next = EMPTY_MARK;
        end

        if (cmd.sw_take) begin
            valid_next[hand_reg] = 1'b1;
            res_hit_next         = 1'b0;
            res_slot_next        = hand_reg;
            res_evict_next       = valid_reg[hand_reg] ? EVICT_W'(vic_reg) : EMPTY_MARK;
        end

        if (cmd.out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg      <= '0;
            hand_reg     <= '0;
            faults_reg   <= '0;
            valid_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            clr_reg      <= clr_next;
            hand_reg     <= hand_next;
            faults_reg   <= faults_next;
            valid_reg    <= valid_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        page_reg      <= page_next;
        vic_reg       <= vic_next;
        cnt_reg       <= cnt_next;
        res_hit_reg   <= res_hit_next;
        res_slot_reg  <= res_slot_next;
        res_evict_reg <= res_evict_next;
        if (cmd.out_load) begin
            m_hit_reg   <= res_hit_reg;
            m_slot_reg  <= SLOT_OUT_W'(res_slot_reg);
            m_evict_reg <= res_evict_reg;
            m_fault_reg <= faults_reg;
        end
    end

    assign m_tvalid       = m_tvalid_reg;
    assign m_hit          = m_hit_reg;
    assign m_frame_slot   = m_slot_reg;
    assign m_evicted_page = m_evict_reg;
    assign m_fault_count  = m_fault_reg;

endmodule
`default_nettype wire

// File: rtl/core/second_chance_page_replacement.sv
`default_nettype none
// ---------------------------------------------------------------------------
// Second-chance page replacement
// Clock replacement over a configurable number of frame slots, one page
// reference in and one result word out per item.
// ---------------------------------------------------------------------------
// Each accepted page reference yields exactly one result word. One reference
// is handled at a time; the next is taken once the previous result sits in
// the output register. The resident search reads the slots in use one at a
// time, through a read state and a compare state for each, and stops at the
// first hit. A fault searches all n slots in use and then runs the clock
// sweep, visiting each slot through the slot and reference-bit memories, at
// most n+1 visits. After reset a clearing pass zeroes the reference bits
// before the first reference is accepted; configuration writes are taken
// during it.
// ---------------------------------------------------------------------------
module second_chance_page_replacement
    import scpr_pkg::*;
#(
    parameter int FRAMES = DEF_FRAMES,
    parameter int PAGES  = DEF_PAGES
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // page referenced [3:0]
    input  wire logic [S_TDATA_W-1:0]  s_tdata,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // hit [0], frame_slot [3:1], evicted_page [8:4], fault_count [24:9]
    output logic      [M_TDATA_W-1:0]  m_tdata,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready
);

    logic [CFG_W-1:0] frames_reg, frames_next;
    logic [CFG_W-1:0] n_used;
    logic             sel_frames;

    scpr_cmd_t cmd;
    scpr_sts_t sts;

    logic                  m_hit;
    logic [SLOT_OUT_W-1:0] m_frame_slot;
    logic [EVICT_W-1:0]    m_evicted_page;
    logic [FAULT_W-1:0]    m_fault_count;

    assign pready     = 1'b1;
    assign sel_frames = (paddr[APB_ADDR_W-1:2] == REG_FRAMES_IN_USE);

    always_comb begin
        frames_next = frames_reg;
        if (psel && penable && pwrite && pready && sel_frames) begin
            frames_next = pwdata[CFG_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frames_reg <= CFG_FRAMES_RESET;
        end else begin
            frames_reg <= frames_next;
        end
    end

    assign prdata = sel_frames ? APB_DATA_W'(frames_reg) : '0;

    // A count of zero means one slot; anything above the slot count is capped.
    always_comb begin
        priority if (frames_reg == '0) begin
            n_used = CFG_W'(1);
        end else if (frames_reg > CFG_W'(FRAMES)) begin
            n_used = CFG_W'(FRAMES);
        end else begin
            n_used = frames_reg;
        end
    end

    scpr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    scpr_datapath #(
        .FRAMES (FRAMES),
        .PAGES  (PAGES)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .sts            (sts),
        .n_used         (n_used),
        .s_page         (s_tdata[PAGE_W-1:0]),
        .m_tready       (m_tready),
        .m_tvalid       (m_tvalid),
        .m_hit          (m_hit),
        .m_frame_slot   (m_frame_slot),
        .m_evicted_page (m_evicted_page),
        .m_fault_count  (m_fault_count)
    );

    assign m_tdata = {
        (M_TDATA_W - 1 - SLOT_OUT_W - EVICT_W - FAULT_W)'(0),
        m_fault_count,
        m_evicted_page,
        m_frame_slot,
        m_hit
    };

`ifndef ASSERT_OFF
    // Only one reference is in flight at a time.
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second reference accepted while one is in flight");

    // The reported slot always lies among the slots in use.
    a_slot_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (CFG_W'(m_frame_slot) < n_used))
        else $error("result slot outside the slots in use");

    // A hit never evicts anything.
    a_hit_no_evict: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_hit |-> (m_evicted_page == EMPTY_MARK))
        else $error("hit reported with an evicted page");

    // A fault has always been counted by the time it is reported.
    a_fault_counted: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_hit |-> (m_fault_count != '0))
        else $error("fault reported with a zero fault count");
`endif

endmodule
`default_nettype wire

// File: bench/testbench.sv
// ---------------------------------------------------------------------------
// Second-chance page replacement: block-level testbench
// Drives page references into the stream input and keeps its own copy of the
// frame slots, reference bits, clock hand and fault count. Every result word
// is checked field by field against that copy. Directed sequences cover slot
// filling, second chances, frame-count corners and pages held twice. They are
// followed by randomised traffic over changing frame counts and flow control.
// ---------------------------------------------------------------------------
module testbench
    import scpr_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [APB_ADDR_W-1:0] FRAMES_ADDR = {REG_FRAMES_IN_USE, 2'b00};

    typedef struct packed {
        logic [FAULT_W-1:0]    fault_count;
        logic [EVICT_W-1:0]    evicted_page;
        logic [SLOT_OUT_W-1:0] frame_slot;
        logic                  hit;
    } ref_outcome_t;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic [S_TDATA_W-1:0]  s_tdata  = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0] paddr    = '0;
    logic [APB_DATA_W-1:0] pwdata   = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // Mirror of the replacement state.
    logic [EVICT_W-1:0] slot_page [DEF_FRAMES];
    bit                 page_ref_bit [DEF_PAGES];
    int                 hand;
    logic [FAULT_W-1:0] fault_total;
    logic [CFG_W-1:0]   frames_reg;

    ref_outcome_t pending_outcomes[$];
    int           mismatches = 0;
    int           src_idle   = 0;
    int           sink_idle  = 0;

    second_chance_page_replacement i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= sink_idle);
    end

    initial begin
        #20_000_000;
        $display("[second_chance_page_replacement] ERROR");
        $finish;
    end

    // One page reference through the clock algorithm, updating the mirror.
    function automatic ref_outcome_t clock_sweep(logic [PAGE_W-1:0] pg);
        int           n;
        int           i;
        int           h;
        bit           found;
        bit           placed;
        ref_outcome_t o;
        n = (frames_reg == 0) ? 1 : (frames_reg > DEF_FRAMES) ? DEF_FRAMES : int'(frames_reg);
        found = 0;
        placed = 0;
        o.hit = 1'b0;
        o.frame_slot = '0;
        o.evicted_page = EMPTY_MARK;
        for (i = 0; i < n; i++) begin
            if (!found && slot_page[i] == {1'b0, pg}) begin
                found = 1;
                o.frame_slot = i[SLOT_OUT_W-1:0];
            end
        end
        if (found) begin
            o.hit = 1'b1;
            page_ref_bit[pg] = 1;
        end else begin
            if (fault_total != FAULT_MAX)
                fault_total = fault_total + 1'b1;
            if (hand >= n)
                hand = 0;
            // n passes clear every bit, so n + 1 visits always find a victim.
            for (i = 0; i <= n; i++) begin
                if (!placed) begin
                    h = hand;
                    if (slot_page[h] == EMPTY_MARK || !page_ref_bit[slot_page[h][PAGE_W-1:0]]) begin
                        o.frame_slot = h[SLOT_OUT_W-1:0];
                        o.evicted_page = slot_page[h];
                        slot_page[h] = {1'b0, pg};
                        placed = 1;
                    end else begin
                        page_ref_bit[slot_page[h][PAGE_W-1:0]] = 0;
                    end
                    hand = (h + 1 >= n) ? 0 : h + 1;
                end
            end
        end
        o.fault_count = fault_total;
        return o;
    endfunction

    task automatic compare_field(input string name, input int want, input int got);
        if (want != got) begin
            mismatches++;
            $display("%0t %s: expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    always @(posedge aclk) begin : result_check
        ref_outcome_t want;
        ref_outcome_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[$bits(ref_outcome_t)-1:0];
            if (pending_outcomes.size() == 0) begin
                mismatches++;
                $display("%0t unexpected result word: expected none, actual %h", $time, got);
            end else begin
                want = pending_outcomes.pop_front();
                compare_field("hit", int'(want.hit), int'(got.hit));
                compare_field("frame_slot", int'(want.frame_slot), int'(got.frame_slot));
                compare_field("evicted_page", int'(want.evicted_page),
                              int'(got.evicted_page));
                compare_field("fault_count", int'(want.fault_count),
                              int'(got.fault_count));
            end
        end
    end

    task automatic send_page(input logic [PAGE_W-1:0] pg);
        while ($urandom_range(99) < src_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_TDATA_W-PAGE_W){1'b0}}, pg};
        do @(posedge aclk); while (!s_tready);
        pending_outcomes = {pending_outcomes, clock_sweep(pg)};
    endtask

    // Hold off the sender until every outstanding result word has come back.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_outcomes.size() != 0)
            @(posedge aclk);
        @(posedge aclk);
    endtask

    // Write the frame count, then read it back.
    task automatic set_frames(input logic [CFG_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= FRAMES_ADDR;
        pwdata  <= {{(APB_DATA_W-CFG_W){1'b0}}, val};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        frames_reg = val;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata != {{(APB_DATA_W-CFG_W){1'b0}}, val}) begin
            mismatches++;
            $display("%0t frames_in_use readback: expected %0d, actual %0d",
                     $time, val, prdata);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Fill every slot, hit a few pages, then force a sweep past set bits.
    task automatic test_fill_and_second_chance();
        int seq[11] = '{0, 15, 0, 15, 1, 2, 3, 4, 5, 6, 7};
        set_frames(4'd8);
        foreach (seq[k])
            send_page(seq[k][PAGE_W-1:0]);
        drain();
    endtask

    // A count of zero acts as one slot, and a hand left beyond it restarts at
    // slot zero; a count above the slot total acts as all slots.
    task automatic test_frame_count_corners();
        set_frames(4'd0);
        send_page(4'd9);
        send_page(4'd9);
        send_page(4'd10);
        drain();
        set_frames(4'd15);
        send_page(4'd10);
        send_page(4'd3);
        send_page(4'd12);
        drain();
    endtask

    // Shrinking hides a slot; growing again leaves the page held twice and
    // the lowest slot must win.
    task automatic test_duplicate_residency();
        set_frames(4'd2);
        send_page(4'd5);
        drain();
        set_frames(4'd8);
        send_page(4'd5);
        send_page(4'd8);
        drain();
    endtask

    // Random references drawn mostly from a small working set so that hits,
    // second chances and evictions all occur often.
    task automatic test_random_traffic(input int src, input int sink);
        int                 ws;
        int                 base;
        logic [CFG_W-1:0]   count;
        logic [PAGE_W-1:0]  pg;
        src_idle  = src;
        sink_idle = sink;
        for (int ph = 0; ph < 8; ph++) begin
            drain();
            case (ph)
                0: count = 4'd1;
                1: count = 4'd8;
                2: count = 4'd0;
                3: count = 4'd15;
                default: count = CFG_W'($urandom_range(15));
            endcase
            set_frames(count);
            ws   = $urandom_range(1, 16);
            base = $urandom_range(15);
            for (int k = 0; k < 60; k++) begin
                if ($urandom_range(9) == 0)
                    pg = PAGE_W'($urandom_range(15));
                else
                    pg = PAGE_W'((base + $urandom_range(ws - 1)) % DEF_PAGES);
                send_page(pg);
            end
        end
        drain();
    endtask

    initial begin
        for (int i = 0; i < DEF_FRAMES; i++)
            slot_page[i] = EMPTY_MARK;
        for (int i = 0; i < DEF_PAGES; i++)
            page_ref_bit[i] = 0;
        hand        = 0;
        fault_total = '0;
        frames_reg  = CFG_FRAMES_RESET;
        src_idle    = 29;
        sink_idle   = 58;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_fill_and_second_chance();
        test_frame_count_corners();
        test_duplicate_residency();
        test_random_traffic(29, 58);
        test_random_traffic(58, 29);
        test_random_traffic(0, 0);

        drain();
        repeat (60) @(posedge aclk);
        if (pending_outcomes.size() != 0) begin
            mismatches++;
            $display("%0t results outstanding: expected 0, actual %0d",
                     $time, pending_outcomes.size());
        end
        if (mismatches == 0) begin
            $display("[second_chance_page_replacement] OK");
        end else begin
            $display("[second_chance_page_replacement] ERROR");
        end
        $finish;
    end

endmodule

// File: second_chance_page_replacement.f
rtl/core/scpr_pkg.sv
rtl/core/scpr_ram.sv
rtl/core/scpr_ctrl.sv
rtl/core/scpr_datapath.sv
rtl/core/second_chance_page_replacement.sv
bench/testbench.sv
